// ===== design/prim_pkg.sv =====
`default_nettype none

package prim_pkg;

  // Width of the tested value (two's complement).
  localparam int unsigned VALUE_WIDTH = 32;
  // Stream data width: the value padded up to whole bytes.
  localparam int unsigned S_DATA_W    = ((VALUE_WIDTH + 7) / 8) * 8;
  // Result data width: one flag padded to a byte.
  localparam int unsigned M_DATA_W    = 8;
  // Bit counter of the serial divider, wide enough to hold VALUE_WIDTH.
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Trial-division constants.
  localparam value_t FIRST_DIV = value_t'(5);
  localparam value_t PAIR_GAP  = value_t'(2);
  localparam value_t STEP_DIV  = value_t'(6);
  localparam value_t THREE     = value_t'(3);
  localparam value_t ONE       = value_t'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV3,
    ST_DIVD,
    ST_DIVD2,
    ST_DONE
  } prim_state_e;

  // Start request to the divider.
  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } prim_div_req_t;

  // Divider result, valid for the cycle in which done is set.
  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } prim_div_rsp_t;

endpackage

`default_nettype wire

// ===== design/prim_div.sv =====
`default_nettype none

// Radix-2 restoring divider: while a division runs, one dividend bit enters the
// partial remainder and one quotient bit leaves per cycle.
module prim_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire prim_pkg::prim_div_req_t req_i,
  output prim_pkg::prim_div_rsp_t      rsp_o
);

  localparam int unsigned W = prim_pkg::VALUE_WIDTH;

  logic [W-1:0]               acc_q, acc_d;
  logic [W-1:0]               rem_q, rem_d;
  logic [W-1:0]               dvs_q, dvs_d;
  logic [prim_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  logic [W:0]   shifted;
  logic [W+1:0] trial;
  logic         fits;

  always_comb begin
    shifted = {rem_q, acc_q[W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    fits    = ~trial[W+1];

    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (req_i.start) begin
      acc_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = prim_pkg::CNT_W'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial[W-1:0] : shifted[W-1:0];
      acc_d = {acc_q[W-2:0], fits};
      cnt_d = cnt_q - prim_pkg::CNT_W'(1);
      if (cnt_q == prim_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = acc_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ===== design/primality_trial_division.sv =====
`default_nettype none

// Negative values, values up to 3 and even values pass from ST_IDLE through ST_DONE into
// the output register; all other values first run the test by 3 and then one serial
// division for each divisor tried, up to about sqrt(value) / 3 divisors.
// Throughput: one request at a time; the next is taken as soon as the result enters the
// output register. Reset (rst_ni low, asynchronous) empties both channels and idles.

module primality_trial_division (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input channel.
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [prim_pkg::S_DATA_W-1:0]  s_axis_tdata_i,  // [VALUE_WIDTH-1:0] value
  // Result channel.
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [prim_pkg::M_DATA_W-1:0]       m_axis_tdata_o   // [0] is_prime, rest zero
);

  localparam int unsigned W = prim_pkg::VALUE_WIDTH;

  prim_pkg::prim_state_e   state_q, state_d;
  prim_pkg::value_t        n_q, n_d;
  prim_pkg::value_t        d_q, d_d;
  logic                    res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_bit_q, out_bit_d;

  prim_pkg::prim_div_req_t div_req;
  prim_pkg::prim_div_rsp_t div_rsp;

  prim_pkg::value_t        in_value;
  logic                    in_fire;
  logic                    out_free;

  assign in_value = s_axis_tdata_i[W-1:0];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready_i;

  // The sequencer screens out the trivial cases, then walks the divisors
  // 3, 5, 7, 11, 13, ... through the serial divider. For each first divisor
  // of a pair, the quotient doubles as the square-root bound: once the
  // divisor exceeds value / divisor, no factor is left and the value is prime.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;

    div_req.start    = 1'b0;
    div_req.dividend = n_q;
    div_req.divisor  = d_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      prim_pkg::ST_IDLE: begin
        if (in_fire) begin
          n_d = in_value;
          if (in_value[W-1]) begin
            res_d   = 1'b0;
            state_d = prim_pkg::ST_DONE;
          end else if (in_value <= prim_pkg::ONE) begin
            res_d   = 1'b0;
            state_d = prim_pkg::ST_DONE;
          end else if (in_value <= prim_pkg::THREE) begin
            res_d   = 1'b1;
            state_d = prim_pkg::ST_DONE;
          end else if (!in_value[0]) begin
            res_d   = 1'b0;
            state_d = prim_pkg::ST_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = in_value;
            div_req.divisor  = prim_pkg::THREE;
            state_d          = prim_pkg::ST_DIV3;
          end
        end
      end

      prim_pkg::ST_DIV3: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            res_d   = 1'b0;
            state_d = prim_pkg::ST_DONE;
          end else begin
            d_d             = prim_pkg::FIRST_DIV;
            div_req.start   = 1'b1;
            div_req.divisor = prim_pkg::FIRST_DIV;
            state_d         = prim_pkg::ST_DIVD;
          end
        end
      end

      prim_pkg::ST_DIVD: begin
        if (div_rsp.done) begin
          if (d_q > div_rsp.quotient) begin
            res_d   = 1'b1;
            state_d = prim_pkg::ST_DONE;
          end else if (div_rsp.remainder == '0) begin
            res_d   = 1'b0;
            state_d = prim_pkg::ST_DONE;
          end else begin
            div_req.start   = 1'b1;
            div_req.divisor = d_q + prim_pkg::PAIR_GAP;
            state_d         = prim_pkg::ST_DIVD2;
          end
        end
      end

      prim_pkg::ST_DIVD2: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            res_d   = 1'b0;
            state_d = prim_pkg::ST_DONE;
          end else begin
            d_d             = d_q + prim_pkg::STEP_DIV;
            div_req.start   = 1'b1;
            div_req.divisor = d_q + prim_pkg::STEP_DIV;
            state_d         = prim_pkg::ST_DIVD;
          end
        end
      end

      prim_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bit_d   = res_q;
          state_d     = prim_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = prim_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prim_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    d_q       <= d_d;
    res_q     <= res_d;
    out_bit_q <= out_bit_d;
  end

  prim_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // A new request is taken only while the sequencer is idle.
  assign s_axis_tready_o = (state_q == prim_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(prim_pkg::M_DATA_W - 1){1'b0}}, out_bit_q};

endmodule

`default_nettype wire

// ===== design/prim_chk.sv =====
`default_nettype none

module prim_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic [prim_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [prim_pkg::M_DATA_W-1:0] m_axis_tdata_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Only one request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while busy");

  // The padding bits of the result are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[prim_pkg::M_DATA_W-1:1] == '0))
    else $error("result padding not zero");

  // A negative value is rejected without trial division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[prim_pkg::VALUE_WIDTH-1]
      && !m_axis_tvalid_o
      |-> ##2 (m_axis_tvalid_o && !m_axis_tdata_o[0]))
    else $error("negative value not rejected at once");

endmodule

bind primality_trial_division prim_chk u_prim_chk (.*);

`default_nettype wire
